/* design/wbps_pkg.sv */
// shared types, constants and helpers of the wildcard byte pattern search
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

  localparam int BYTE_W        = 8;
  localparam int ADDR_W        = 64;
  localparam int PAT_REG_BYTES = 24;
  localparam int PAT_W         = PAT_REG_BYTES * BYTE_W;
  localparam int CARE_W        = 24;
  localparam int LEN_W         = 5;
  localparam int REG_IDX_W     = 3;
  localparam int OP_BYTES      = 4;
  localparam int OP_W          = OP_BYTES * BYTE_W;
  localparam int OP_OFS        = 3;
  localparam int INSN_LEN      = 7;
  localparam int OFF_W         = 34;
  localparam int CNT_W         = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PAT_LO   = 3'd0,
    REG_PAT_MID  = 3'd1,
    REG_PAT_HI   = 3'd2,
    REG_CARE     = 3'd3,
    REG_LEN      = 3'd4,
    REG_BASE     = 3'd5,
    REG_RELATIVE = 3'd6
  } reg_idx_e;

  // expected byte and care flag handed to one window cell
  typedef struct packed {
    logic              care;
    logic [BYTE_W-1:0] pat;
  } cell_ref_t;

  // pattern byte k of the concatenated pattern registers
  function automatic logic [BYTE_W-1:0] pat_byte(input logic [PAT_W-1:0] pat,
                                                 input logic [LEN_W-1:0] k);
    logic [PAT_W-1:0] sh;
    sh = pat >> {k, 3'b000};
    return sh[BYTE_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/wbps_stream_if.sv */
// stream channels: byte input and search result output
`timescale 1ns / 1ps
`default_nettype none

interface wbps_in_if;
  logic                      valid;
  logic                      ready;
  logic [wbps_pkg::BYTE_W-1:0] data_byte;
  logic                      last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface wbps_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [wbps_pkg::ADDR_W-1:0] match_address;

  modport source (output valid, output found, output match_address, input ready);
  modport sink   (input valid, input found, input match_address, output ready);
endinterface

`default_nettype wire

/* design/wbps_cell.sv */
// one window cell: holds a byte, passes it on, compares the byte it takes in
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell (
  input  wire logic                          clk_i,
  input  wire logic                          shift_i,
  input  wire logic [wbps_pkg::BYTE_W-1:0]   byte_i,
  input  wire wbps_pkg::cell_ref_t           ref_i,
  output logic      [wbps_pkg::BYTE_W-1:0]   byte_o,
  output logic                               hit_o
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  assign byte_o = byte_q;
  // wildcard or equal byte
  assign hit_o  = !ref_i.care || (byte_i == ref_i.pat);

endmodule

`default_nettype wire

/* design/wildcard_byte_pattern_search.sv */
// a result passes the address stage, then the output register, after its last byte transfers
// throughput: one byte per cycle unless stalled, set by the masked compare of the cell row
// the byte input stalls only while a finished result waits in both the address stage
// and the output register
// reset (asynchronous, active low) clears the configuration registers to zero and
// puts the search back to the start of a region; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_search #(
  parameter int MAX_PATTERN_BYTES = 24
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [wbps_pkg::REG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [wbps_pkg::ADDR_W-1:0]       cfg_data_i,
  wbps_in_if.sink                                src_i,
  wbps_out_if.source                             res_o
);
  import wbps_pkg::*;

  // usable pattern length: bounded by the window and by the pattern registers
  localparam int CAP = (MAX_PATTERN_BYTES < PAT_REG_BYTES) ? MAX_PATTERN_BYTES
                                                           : PAT_REG_BYTES;

  typedef enum logic [1:0] {
    PH_SEARCHING,
    PH_AWAIT_OPERAND,
    PH_FOUND
  } phase_e;

  // configuration registers
  logic [ADDR_W-1:0] pat_lo_q, pat_mid_q, pat_hi_q;
  logic [CARE_W-1:0] care_q;
  logic [LEN_W-1:0]  len_q;
  logic [ADDR_W-1:0] base_q;
  logic              rel_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_lo_q  <= '0;
      pat_mid_q <= '0;
      pat_hi_q  <= '0;
      care_q    <= '0;
      len_q     <= '0;
      base_q    <= '0;
      rel_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_PAT_LO:   pat_lo_q  <= cfg_data_i;
        REG_PAT_MID:  pat_mid_q <= cfg_data_i;
        REG_PAT_HI:   pat_hi_q  <= cfg_data_i;
        REG_CARE:     care_q    <= cfg_data_i[CARE_W-1:0];
        REG_LEN:      len_q     <= cfg_data_i[LEN_W-1:0];
        REG_BASE:     base_q    <= cfg_data_i;
        REG_RELATIVE: rel_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // search state and pipeline registers
  phase_e            phase_q, phase_step;
  logic [ADDR_W-1:0] idx_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] x_q, x_d;      // address relative to region base
  logic [ADDR_W-1:0] hit_base_q;    // region base as it stood when the address was formed
  logic              a1_valid_q, a1_found_q;
  logic              out_valid_q, out_found_q;
  logic [ADDR_W-1:0] out_addr_q;

  logic in_xfer, out_free;

  assign out_free    = !out_valid_q || res_o.ready;
  assign src_i.ready = !a1_valid_q || out_free;
  assign in_xfer     = src_i.valid && src_i.ready;

  // cell row: w_new is the window after the incoming byte enters
  logic [BYTE_W-1:0] win   [CAP];
  logic [BYTE_W-1:0] w_new [CAP];
  cell_ref_t         cref  [CAP];
  logic [CAP-1:0]    hits;
  logic [PAT_W-1:0]  pat_all;
  logic [LEN_W-1:0]  len_m1;

  assign pat_all = {pat_hi_q, pat_mid_q, pat_lo_q};
  assign len_m1  = len_q - LEN_W'(1);

  for (genvar j = 0; j < CAP; j++) begin : g_cell
    logic [LEN_W-1:0]  k;
    logic [CARE_W-1:0] care_sh;

    // cell j lines up with pattern byte len-1-j
    assign k       = len_m1 - LEN_W'(j);
    assign care_sh = care_q >> k;
    assign cref[j] = '{care: (LEN_W'(j) < len_q) && care_sh[0], pat: pat_byte(pat_all, k)};

    if (j == 0) begin : g_head
      assign w_new[j] = src_i.data_byte;
    end else begin : g_body
      assign w_new[j] = win[j-1];
    end

    wbps_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (in_xfer),
      .byte_i  (w_new[j]),
      .ref_i   (cref[j]),
      .byte_o  (win[j]),
      .hit_o   (hits[j])
    );
  end

  // full match: legal length, enough bytes seen, every cell agrees
  logic len_ok, filled, match;

  assign len_ok = (len_q != '0) && (len_q <= LEN_W'(CAP));
  assign filled = (idx_q[ADDR_W-1:LEN_W] != '0) || (idx_q[LEN_W-1:0] >= len_m1);
  assign match  = len_ok && filled && (&hits);

  // operand pick: distance from match start to the current byte
  logic [LEN_W-1:0]  span;
  logic [BYTE_W-1:0] opb [OP_BYTES];
  logic [OP_W-1:0]   op;
  logic              use_op;
  logic [OFF_W-1:0]  op_ext, span_ext, off;

  assign span = (phase_q == PH_AWAIT_OPERAND) ? LEN_W'(INSN_LEN - 1) : len_m1;

  always_comb begin
    logic [LEN_W-1:0] pos;
    for (int j = 0; j < OP_BYTES; j++) begin
      pos    = span - LEN_W'(OP_OFS + j);
      opb[j] = '0;
      for (int m = 0; m < CAP; m++) begin
        if (pos == LEN_W'(m)) begin
          opb[j] = w_new[m];
        end
      end
    end
  end

  assign op       = {opb[3], opb[2], opb[1], opb[0]};
  assign use_op   = (phase_q == PH_AWAIT_OPERAND) || rel_q;
  assign op_ext   = {{(OFF_W-OP_W){op[OP_W-1]}}, op};
  assign span_ext = {{(OFF_W-LEN_W){1'b0}}, span};
  // relative: start + 7 + operand; plain: start; start = current index - span
  assign off      = use_op ? (op_ext + OFF_W'(INSN_LEN) - span_ext) : ('0 - span_ext);
  assign x_d      = idx_q + {{(ADDR_W-OFF_W){off[OFF_W-1]}}, off};

  // phase advance for one transferred byte
  logic resolve;

  always_comb begin
    phase_step = phase_q;
    cnt_d      = cnt_q;
    resolve    = 1'b0;
    case (phase_q)
      PH_SEARCHING: begin
        if (match) begin
          if (!rel_q || (len_q >= LEN_W'(INSN_LEN))) begin
            resolve    = 1'b1;
            phase_step = PH_FOUND;
          end else begin
            // operand still to come: count bytes until its last one
            phase_step = PH_AWAIT_OPERAND;
            cnt_d      = CNT_W'(LEN_W'(INSN_LEN) - len_q);
          end
        end
      end
      PH_AWAIT_OPERAND: begin
        if (cnt_q == CNT_W'(1)) begin
          resolve    = 1'b1;
          phase_step = PH_FOUND;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      PH_FOUND: ;
      default: phase_step = PH_SEARCHING;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SEARCHING;
      idx_q       <= '0;
      cnt_q       <= '0;
      x_q         <= '0;
      hit_base_q  <= '0;
      a1_valid_q  <= 1'b0;
      a1_found_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
      out_addr_q  <= '0;
    end else begin
      if (in_xfer) begin
        cnt_q <= cnt_d;
        if (resolve) begin
          x_q        <= x_d;
          hit_base_q <= base_q;
        end
        // region end restarts the search
        if (src_i.last_byte) begin
          phase_q <= PH_SEARCHING;
          idx_q   <= '0;
        end else begin
          phase_q <= phase_step;
          idx_q   <= idx_q + ADDR_W'(1);
        end
      end

      // address stage holds the region verdict until the output register frees
      if (!a1_valid_q || out_free) begin
        a1_valid_q <= in_xfer && src_i.last_byte;
        a1_found_q <= (phase_step == PH_FOUND);
      end

      if (out_free) begin
        out_valid_q <= a1_valid_q;
        if (a1_valid_q) begin
          out_found_q <= a1_found_q;
          out_addr_q  <= a1_found_q ? (hit_base_q + x_q) : '0;
        end
      end
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.found         = out_found_q;
  assign res_o.match_address = out_addr_q;

endmodule

`default_nettype wire

/* design/wbps_checker.sv */
// port-level checks of the wildcard byte pattern search, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module wbps_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        in_last_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic                        out_found_i,
  input wire logic [wbps_pkg::ADDR_W-1:0] out_addr_i
);
  import wbps_pkg::*;

  // not-found results carry a zero address
  a_notfound_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_found_i) |-> (out_addr_i == '0))
    else $error("not-found result with non-zero address");

  // a fresh result follows the transfer of a region's last byte
  a_result_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i && in_last_i, 2))
    else $error("result without a preceding last byte");

  // the byte input only stalls behind a blocked result
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("byte input stalled without output back-pressure");

  // a stalled result holds
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_found_i) && $stable(out_addr_i)))
    else $error("stalled result changed");

endmodule

bind wildcard_byte_pattern_search wbps_checker u_wbps_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (src_i.valid),
  .in_ready_i  (src_i.ready),
  .in_last_i   (src_i.last_byte),
  .out_valid_i (res_o.valid),
  .out_ready_i (res_o.ready),
  .out_found_i (res_o.found),
  .out_addr_i  (res_o.match_address)
);

`default_nettype wire
